FILE: src/wpr_pkg.sv
// Package for the word prefix replacer: byte constants, register indexes and shared types.
// Used by src/word_prefix_replacer.sv; it depends on nothing else.

package wpr_pkg;

    // Widths fixed by the register and stream formats.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 4;

    // Special characters of the text.
    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYWORD_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    // Prefix match progress of the current word.
    typedef enum logic [1:0] {
        MODE_MATCHING   = 2'd0,
        MODE_MATCHED    = 2'd1,
        MODE_MISMATCHED = 2'd2
    } t_mode;

    // Which register a job's leading byte run is read from.
    typedef enum logic {
        SEG_KEYWORD     = 1'b0,
        SEG_REPLACEMENT = 1'b1
    } t_seg_src;

    // Output work that one input item leaves behind: a run of register bytes,
    // then up to two tail bytes (the second tail byte is always a newline).
    typedef struct packed {
        t_seg_src         seg_src;
        logic [LEN_W-1:0] seg_n;
        logic [1:0]       tail_n;
        logic [7:0]       tail0;
        logic             eot;
    } t_job;

endpackage

FILE: src/word_prefix_replacer.sv
// Top level of the word prefix replacer: item decode, word state, job register and output stage.
// Depends on wpr_pkg for constants, register indexes and the job type.

// Text enters one byte per item and leaves as rewritten bytes, one per cycle while the
// output is not stalled. Each accepted item is decoded in the cycle it is taken into a job
// of 0 to 9 output bytes (default sizes), held in a single job register; the output register
// takes one byte of that job per cycle unless the output stalls. An item that yields more
// than one byte keeps the input stalled until the job register has passed its last byte to
// the output register. The output register lets the next item be taken while a finished
// byte still waits downstream. Configuration is read live and must only be written while
// no job is pending.

module word_prefix_replacer #(
    parameter int KEY_MAX_BYTES     = 8,
    parameter int REPLACE_MAX_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [wpr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wpr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,   // [7:0] text_byte
    input  logic                             i_s_axis_tlast,   // end_of_text
    // Output stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata,   // [7:0] out_byte
    output logic                             o_m_axis_tlast,   // run_last
    output logic                             o_m_axis_tuser    // [0] text_done
);

    localparam int KIDX = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam int RIDX = (REPLACE_MAX_BYTES > 1) ? $clog2(REPLACE_MAX_BYTES) : 1;
    localparam logic [wpr_pkg::LEN_W-1:0] KMAX = wpr_pkg::LEN_W'(KEY_MAX_BYTES);
    localparam logic [wpr_pkg::LEN_W-1:0] RMAX = wpr_pkg::LEN_W'(REPLACE_MAX_BYTES);

    // Configuration registers.
    logic [7:0]                r_key [KEY_MAX_BYTES];
    logic [7:0]                r_rep [REPLACE_MAX_BYTES];
    logic [wpr_pkg::LEN_W-1:0] r_key_len;
    logic [wpr_pkg::LEN_W-1:0] r_rep_len;

    // Word state.
    logic                      r_in_word, n_in_word;
    logic [wpr_pkg::LEN_W-1:0] r_mc, n_mc;
    wpr_pkg::t_mode            r_mode, n_mode;

    // Job register and output stage.
    wpr_pkg::t_job             r_job, n_job;
    logic                      r_job_valid;
    logic [wpr_pkg::LEN_W-1:0] r_idx;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;
    logic                      r_out_done;

    logic                      has_job;
    logic                      accept;
    logic                      out_load;
    logic                      job_done;
    logic                      idx_last;
    logic [wpr_pkg::LEN_W-1:0] job_total;
    logic [wpr_pkg::LEN_W-1:0] key_len;
    logic [wpr_pkg::LEN_W-1:0] rep_len;
    logic [wpr_pkg::LEN_W-1:0] cur_mc;
    logic [wpr_pkg::LEN_W-1:0] mc_inc;
    logic [wpr_pkg::LEN_W-1:0] held_n;
    wpr_pkg::t_mode            cur_mode;
    logic [7:0]                emit_byte;

    // Lengths above the storage size count as the storage size.
    assign key_len = (r_key_len > KMAX) ? KMAX : r_key_len;
    assign rep_len = (r_rep_len > RMAX) ? RMAX : r_rep_len;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_MAX_BYTES; i++) begin
                r_key[i] <= 8'h00;
            end
            for (int i = 0; i < REPLACE_MAX_BYTES; i++) begin
                r_rep[i] <= 8'h00;
            end
            r_key_len <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wpr_pkg::CFG_KEYWORD_BYTES: begin
                    for (int i = 0; i < KEY_MAX_BYTES; i++) begin
                        r_key[i] <= i_cfg_data[8*i +: 8];
                    end
                end
                wpr_pkg::CFG_KEYWORD_LENGTH: begin
                    r_key_len <= i_cfg_data[wpr_pkg::LEN_W-1:0];
                end
                wpr_pkg::CFG_REPLACEMENT_BYTES: begin
                    for (int i = 0; i < REPLACE_MAX_BYTES; i++) begin
                        r_rep[i] <= i_cfg_data[8*i +: 8];
                    end
                end
                wpr_pkg::CFG_REPLACEMENT_LENGTH: begin
                    r_rep_len <= i_cfg_data[wpr_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Output handshake: a byte moves into the output register whenever it is free or drains.
    assign job_total       = r_job.seg_n + wpr_pkg::LEN_W'(r_job.tail_n);
    assign idx_last        = (r_idx == job_total - wpr_pkg::LEN_W'(1));
    assign out_load        = r_job_valid && (!r_out_valid || i_m_axis_tready);
    assign job_done        = out_load && idx_last;
    assign o_s_axis_tready = !r_job_valid || job_done;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Decode of one item against the word state.
    assign cur_mc   = r_in_word ? r_mc : '0;
    assign cur_mode = r_in_word ? r_mode : wpr_pkg::MODE_MATCHING;
    assign mc_inc   = cur_mc + wpr_pkg::LEN_W'(1);
    assign held_n   = (r_in_word && r_mode == wpr_pkg::MODE_MATCHING) ? r_mc : '0;

    always_comb begin
        n_in_word     = r_in_word;
        n_mc          = r_mc;
        n_mode        = r_mode;
        has_job       = 1'b0;
        n_job.seg_src = wpr_pkg::SEG_KEYWORD;
        n_job.seg_n   = '0;
        n_job.tail_n  = 2'd0;
        n_job.tail0   = i_s_axis_tdata;
        n_job.eot     = 1'b0;
        if (i_s_axis_tlast) begin
            // End of text: flush the word, then the closing newline.
            has_job      = 1'b1;
            n_job.eot    = 1'b1;
            n_job.seg_n  = held_n;
            n_job.tail_n = r_in_word ? 2'd2 : 2'd1;
            n_job.tail0  = r_in_word ? wpr_pkg::SPACE_BYTE : wpr_pkg::NEWLINE_BYTE;
            n_in_word    = 1'b0;
            n_mc         = '0;
            n_mode       = wpr_pkg::MODE_MATCHING;
        end else if (i_s_axis_tdata == wpr_pkg::SPACE_BYTE) begin
            // Space: closes a word if one is open.
            has_job      = r_in_word;
            n_job.seg_n  = held_n;
            n_job.tail_n = 2'd1;
            n_job.tail0  = wpr_pkg::SPACE_BYTE;
            n_in_word    = 1'b0;
            n_mc         = '0;
            n_mode       = wpr_pkg::MODE_MATCHING;
        end else begin
            // Word character.
            n_in_word = 1'b1;
            n_mc      = cur_mc;
            n_mode    = cur_mode;
            if (cur_mode != wpr_pkg::MODE_MATCHING) begin
                has_job      = 1'b1;
                n_job.tail_n = 2'd1;
            end else if (cur_mc >= key_len) begin
                // Match already complete: replacement, then this character.
                has_job       = 1'b1;
                n_mode        = wpr_pkg::MODE_MATCHED;
                n_job.seg_src = wpr_pkg::SEG_REPLACEMENT;
                n_job.seg_n   = rep_len;
                n_job.tail_n  = 2'd1;
            end else if (i_s_axis_tdata == r_key[cur_mc[KIDX-1:0]]) begin
                // Character held back; the last keyword character releases the replacement.
                n_mc = mc_inc;
                if (mc_inc >= key_len) begin
                    n_mode        = wpr_pkg::MODE_MATCHED;
                    has_job       = (rep_len != '0);
                    n_job.seg_src = wpr_pkg::SEG_REPLACEMENT;
                    n_job.seg_n   = rep_len;
                end
            end else begin
                // Mismatch: held-back keyword bytes, then this character.
                has_job      = 1'b1;
                n_mode       = wpr_pkg::MODE_MISMATCHED;
                n_job.seg_n  = cur_mc;
                n_job.tail_n = 2'd1;
            end
        end
    end

    // Word state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_mc      <= '0;
            r_mode    <= wpr_pkg::MODE_MATCHING;
        end else if (accept) begin
            r_in_word <= n_in_word;
            r_mc      <= n_mc;
            r_mode    <= n_mode;
        end
    end

    // Job register with its byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (accept && has_job) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end else if (out_load) begin
            r_idx <= r_idx + wpr_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_job) begin
            r_job <= n_job;
        end
    end

    // Byte selection: register run first, then the tail bytes.
    always_comb begin
        if (r_idx < r_job.seg_n) begin
            if (r_job.seg_src == wpr_pkg::SEG_REPLACEMENT) begin
                emit_byte = r_rep[r_idx[RIDX-1:0]];
            end else begin
                emit_byte = r_key[r_idx[KIDX-1:0]];
            end
        end else if (r_idx == r_job.seg_n) begin
            emit_byte = r_job.tail0;
        end else begin
            emit_byte = wpr_pkg::NEWLINE_BYTE;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= emit_byte;
            r_out_last <= idx_last;
            r_out_done <= idx_last && r_job.eot;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_done;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for word_prefix_replacer: directed and random text streams
// against a scoreboard that predicts every output byte. Depends on src/wpr_pkg.sv.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 230;
    localparam int QUIET_ITEMS    = 40;
    localparam int SETTLE_CYCLES  = 16;
    localparam int FINAL_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int KEY_BYTES      = 8;
    localparam int REPLACE_BYTES  = 8;

    // One expected output item of the rewritten text.
    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } t_text_out;

    // Predicts the rewritten text and checks the bytes that come out.
    class t_text_scoreboard;
        logic [63:0]    kw_bytes;
        logic [3:0]     kw_len;
        logic [63:0]    rep_bytes;
        logic [3:0]     rep_len;
        bit             in_word;
        logic [3:0]     n_matched;
        wpr_pkg::t_mode mode;
        t_text_out      expected_q[$];
        int             errors;

        function new();
            kw_bytes  = '0;
            kw_len    = '0;
            rep_bytes = '0;
            rep_len   = '0;
            in_word   = 1'b0;
            n_matched = '0;
            mode      = wpr_pkg::MODE_MATCHING;
            errors    = 0;
        endfunction

        function void set_reg(logic [wpr_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
            case (idx)
                wpr_pkg::CFG_KEYWORD_BYTES:      kw_bytes  = value;
                wpr_pkg::CFG_KEYWORD_LENGTH:     kw_len    = value[3:0];
                wpr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = value;
                wpr_pkg::CFG_REPLACEMENT_LENGTH: rep_len   = value[3:0];
                default: ;
            endcase
        endfunction

        // Lengths above the register capacity count as full.
        function int eff_key_len();
            return (kw_len > KEY_BYTES) ? KEY_BYTES : int'(kw_len);
        endfunction

        function logic [7:0] kw_byte(int i);
            return kw_bytes[(i % 8) * 8 +: 8];
        endfunction

        function void push_byte(logic [7:0] b, logic done);
            t_text_out item;
            item.out_byte  = b;
            item.run_last  = 1'b0;
            item.text_done = done;
            expected_q.push_back(item);
        endfunction

        // Keyword bytes held back while matching come from the live register.
        function void push_held();
            int n;
            n = (n_matched > KEY_BYTES) ? KEY_BYTES : int'(n_matched);
            for (int i = 0; i < n; i++) push_byte(kw_byte(i), 1'b0);
        endfunction

        function void push_replacement();
            int n;
            n = (rep_len > REPLACE_BYTES) ? REPLACE_BYTES : int'(rep_len);
            for (int i = 0; i < n; i++) push_byte(rep_bytes[i * 8 +: 8], 1'b0);
        endfunction

        function void close_word();
            if (in_word) begin
                if (mode == wpr_pkg::MODE_MATCHING) push_held();
                push_byte(wpr_pkg::SPACE_BYTE, 1'b0);
            end
            in_word   = 1'b0;
            n_matched = '0;
            mode      = wpr_pkg::MODE_MATCHING;
        endfunction

        function void take_char(logic [7:0] b);
            int k;
            k = eff_key_len();
            if (!in_word) begin
                in_word   = 1'b1;
                n_matched = '0;
                mode      = wpr_pkg::MODE_MATCHING;
            end
            if (mode != wpr_pkg::MODE_MATCHING) begin
                push_byte(b, 1'b0);
                return;
            end
            // Keyword already complete (empty, or shortened mid-word).
            if (n_matched >= k) begin
                mode = wpr_pkg::MODE_MATCHED;
                push_replacement();
                push_byte(b, 1'b0);
                return;
            end
            if (b == kw_byte(n_matched)) begin
                n_matched++;
                if (n_matched >= k) begin
                    mode = wpr_pkg::MODE_MATCHED;
                    push_replacement();
                end
            end else begin
                mode = wpr_pkg::MODE_MISMATCHED;
                push_held();
                push_byte(b, 1'b0);
            end
        endfunction

        // Called for every accepted input item.
        function void note_input(logic [7:0] b, logic eot);
            int n0;
            n0 = expected_q.size();
            if (eot) begin
                close_word();
                push_byte(wpr_pkg::NEWLINE_BYTE, 1'b1);
            end else if (b == wpr_pkg::SPACE_BYTE) begin
                close_word();
            end else begin
                take_char(b);
            end
            if (expected_q.size() > n0) expected_q[expected_q.size() - 1].run_last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Called for every accepted output item.
        task check_result(logic [7:0] b, logic is_last, logic done);
            t_text_out item;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h last %b done %b", b, is_last, done));
                return;
            end
            item = expected_q.pop_front();
            if (b !== item.out_byte)
                report_mismatch($sformatf("out_byte %h, expected %h", b, item.out_byte));
            if (is_last !== item.run_last)
                report_mismatch($sformatf("run_last %b, expected %b (byte %h)",
                                          is_last, item.run_last, item.out_byte));
            if (done !== item.text_done)
                report_mismatch($sformatf("text_done %b, expected %b (byte %h)",
                                          done, item.text_done, item.out_byte));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [wpr_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [wpr_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [7:0]                      i_s_axis_tdata = '0;
    logic                            i_s_axis_tlast = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [7:0]                      o_m_axis_tdata;
    logic                            o_m_axis_tlast;
    logic                            o_m_axis_tuser;

    t_text_scoreboard sb;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;

    word_prefix_replacer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: check each accepted item, then stall in random bursts.
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one text item, with an optional random gap first, and wait for it to be taken.
    task send_text_item(logic [7:0] b, logic eot);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(b, eot);
        items_sent++;
    endtask

    task send_char(logic [7:0] b);
        send_text_item(b, 1'b0);
    endtask

    task send_eot();
        send_text_item(8'($urandom), 1'b1);
    endtask

    // Hold the sender until every expected byte has come out.
    task drain_output();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    // Bring the block to idle before a register write.
    task settle();
        drain_output();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [wpr_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [7:0] word_char_rand();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == wpr_pkg::SPACE_BYTE) b = b ^ 8'h01;
        return b;
    endfunction

    // Length register value, sometimes with junk above the 4-bit field.
    function logic [63:0] length_value(int len);
        logic [63:0] v;
        v = '0;
        if ($urandom_range(0, 3) == 0) v = {$urandom, $urandom};
        v[3:0] = len[3:0];
        return v;
    endfunction

    function int length_pick();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 8;
            2:       return $urandom_range(9, 15);
            default: return $urandom_range(1, 7);
        endcase
    endfunction

    // One word from a mix of full matches, short prefixes, near misses and noise.
    task send_random_word();
        int k;
        int n;
        int kind;
        logic [7:0] b;
        k    = sb.eff_key_len();
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                for (int i = 0; i < k; i++) send_char(sb.kw_byte(i));
                n = $urandom_range(0, 3);
                repeat (n) send_char(word_char_rand());
            end
            4, 5: begin
                n = (k > 0) ? $urandom_range(1, k) : 1;
                for (int i = 0; i < n - 1; i++) send_char(sb.kw_byte(i));
                if (k == 0) send_char(word_char_rand());
            end
            6: begin
                n = $urandom_range(0, k);
                for (int i = 0; i < n; i++) send_char(sb.kw_byte(i));
                b = (n < k) ? sb.kw_byte(n) ^ 8'($urandom_range(1, 255)) : word_char_rand();
                send_char(b);
                repeat ($urandom_range(0, 3)) send_char(word_char_rand());
            end
            7: begin
                repeat ($urandom_range(1, 5)) send_char(word_char_rand());
            end
            8: begin
                // Raw noise: any byte, spaces and end of text included.
                repeat ($urandom_range(1, 4))
                    send_text_item(8'($urandom), $urandom_range(0, 7) == 0);
            end
            default: begin
                drain_output();
                send_char(word_char_rand());
            end
        endcase
        case ($urandom_range(0, 9))
            0:       send_eot();
            1:       ;
            2:       repeat ($urandom_range(2, 3)) send_char(wpr_pkg::SPACE_BYTE);
            default: send_char(wpr_pkg::SPACE_BYTE);
        endcase
    endtask

    // New settings while idle, then a run of random words; a word may be left open.
    task run_random_phase(int n_items, bit quiet);
        logic [63:0] kw;
        int stop;
        settle();
        tx_idle_en = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
        rx_idle_en = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) == 0) begin
            kw = {$urandom, $urandom};
        end else begin
            for (int i = 0; i < 8; i++) kw[i * 8 +: 8] = 8'($urandom_range(8'h61, 8'h64));
        end
        write_reg(wpr_pkg::CFG_KEYWORD_BYTES, kw);
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(length_pick()));
        write_reg(wpr_pkg::CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_reg(wpr_pkg::CFG_REPLACEMENT_LENGTH, length_value(length_pick()));
        stop = items_sent + n_items;
        while (items_sent < stop) send_random_word();
    endtask

    initial begin : main
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty keyword and empty replacement, words pass through.
        send_char(wpr_pkg::SPACE_BYTE);
        send_char(8'h78);
        send_char(wpr_pkg::SPACE_BYTE);
        send_char(wpr_pkg::SPACE_BYTE);
        send_eot();
        send_eot();

        // Two-byte keyword, full-size replacement.
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_BYTES, 64'h6261);
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(2));
        write_reg(wpr_pkg::CFG_REPLACEMENT_BYTES, 64'h535455565758595A);
        write_reg(wpr_pkg::CFG_REPLACEMENT_LENGTH, length_value(8));
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);
        send_char(wpr_pkg::SPACE_BYTE);
        // Word shorter than the keyword.
        send_char(8'h61);
        send_char(wpr_pkg::SPACE_BYTE);
        // Mismatch after a partial match.
        send_char(8'h61);
        send_char(8'h78);
        send_char(wpr_pkg::SPACE_BYTE);
        // Extreme byte values as word characters.
        send_char(8'h00);
        send_char(8'hFF);
        send_eot();
        // End of text while bytes are still held back.
        send_char(8'h61);
        send_eot();

        // Keyword shortened in the middle of a matching word.
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_BYTES, 64'h636261);
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(3));
        send_char(8'h61);
        send_char(8'h62);
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(1));
        send_char(8'h63);
        send_char(wpr_pkg::SPACE_BYTE);

        // Keyword bytes rewritten while a byte is held back.
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(2));
        send_char(8'h61);
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_BYTES, 64'h6271);
        send_char(wpr_pkg::SPACE_BYTE);

        // Oversized lengths with an empty keyword.
        settle();
        write_reg(wpr_pkg::CFG_KEYWORD_LENGTH, length_value(0));
        write_reg(wpr_pkg::CFG_REPLACEMENT_LENGTH, length_value(15));
        send_char(8'h71);
        send_eot();

        // Random part, quiet at the end.
        while (items_sent < ITEM_TARGET - QUIET_ITEMS) run_random_phase($urandom_range(8, 30), 1'b0);
        run_random_phase(QUIET_ITEMS, 1'b1);

        drain_output();
        repeat (FINAL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
